// File: src/ata_pkg.sv
// shared types and constants for the accelerometer tilt angle pipeline
`default_nettype none

package ata_pkg;

  // sample and result widths
  localparam int unsigned AccelW = 16;
  localparam int unsigned AngW   = 15;

  // square root datapath: radicand is the sum of squares shifted left by 28
  localparam int unsigned SqW    = 32;
  localparam int unsigned RootW  = 30;
  localparam int unsigned RemW   = 32;

  // cordic datapath
  localparam int unsigned XyW    = 34;
  localparam int unsigned ZW     = 32;
  localparam int unsigned NumShift = 14;
  localparam int unsigned TabLen = 24;

  // output scaling: 18000/pi in Q16, rounding at bit 46
  localparam int unsigned MagW   = 31;
  localparam int unsigned KW     = 29;
  localparam int unsigned ProdW  = MagW + KW;
  localparam int unsigned RndBit = 46;
  localparam int unsigned ResW   = ProdW + 1 - RndBit;
  localparam logic [KW-1:0] Deg100PerRad = KW'(375493621);
  localparam logic [ResW-1:0] AngMax = ResW'(9000);

  // atan(2^-i) in radians scaled by 2^30, truncated
  localparam logic [ZW-1:0] AtanTab [TabLen] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // samples that bypass the angle computation
  typedef enum logic [1:0] {
    SpecNone = 2'd0,
    SpecZero = 2'd1,
    SpecPos  = 2'd2,
    SpecNeg  = 2'd3
  } spec_e;

  // payload moving down the square root cells
  typedef struct packed {
    logic signed [AccelW-1:0] num;
    spec_e                    spec;
    logic [SqW-1:0]           rad;
    logic [RemW-1:0]          rem;
    logic [RootW-1:0]         root;
  } sqrt_t;

  // payload moving down the cordic cells
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    spec_e                 spec;
  } cordic_t;

endpackage

`default_nettype wire

// File: src/ata_front.sv
// axis selection, squaring and sum of squares ahead of the square root chain
`default_nettype none

module ata_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              mode_i,
  input  wire                              valid_i,
  output logic                             ready_o,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_x_i,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_y_i,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_z_i,
  output logic                             valid_o,
  input  wire                              ready_i,
  output ata_pkg::sqrt_t                   data_o
);
  import ata_pkg::*;

  logic signed [AccelW-1:0] num, oth_a;
  logic signed [2*AccelW-1:0] prod_a, prod_b;
  spec_e spec;

  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;
  logic signed [AccelW-1:0] s1_num_q;
  spec_e s1_spec_q;
  logic [SqW-1:0] s1_sqa_q, s1_sqb_q;
  sqrt_t s2_data_q;

  // roll uses y over x,z; pitch uses x over y,z
  always_comb begin
    num   = mode_i ? accel_x_i : accel_y_i;
    oth_a = mode_i ? accel_y_i : accel_x_i;
    prod_a = oth_a * oth_a;
    prod_b = accel_z_i * accel_z_i;
    if (num == '0) begin
      spec = SpecZero;
    end else if (oth_a == '0 && accel_z_i == '0) begin
      spec = num[AccelW-1] ? SpecNeg : SpecPos;
    end else begin
      spec = SpecNone;
    end
  end

  // stall handshake through both stages
  assign s2_ready = ~s2_valid_q | ready_i;
  assign s1_ready = ~s1_valid_q | s2_ready;
  assign ready_o  = s1_ready;

  // stage one: squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_num_q  <= num;
      s1_spec_q <= spec;
      s1_sqa_q  <= SqW'(unsigned'(prod_a));
      s1_sqb_q  <= SqW'(unsigned'(prod_b));
    end
  end

  // stage two: sum of squares starts the root extraction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_data_q.num  <= s1_num_q;
      s2_data_q.spec <= s1_spec_q;
      s2_data_q.rad  <= s1_sqa_q + s1_sqb_q;
      s2_data_q.rem  <= '0;
      s2_data_q.root <= '0;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_data_q;

endmodule

`default_nettype wire

// File: src/ata_sqrt_cell.sv
// one cell of the square root chain: resolves one root bit per cell
`default_nettype none

module ata_sqrt_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             valid_i,
  output logic            ready_o,
  input  ata_pkg::sqrt_t  data_i,
  output logic            valid_o,
  input  wire             ready_i,
  output ata_pkg::sqrt_t  data_o
);
  import ata_pkg::*;

  logic valid_q;
  sqrt_t data_q, data_d;
  logic [RemW+1:0] rem_w, trial;

  // bring down the next two radicand bits and try a one root bit
  always_comb begin
    rem_w = {data_i.rem, data_i.rad[SqW-1 -: 2]};
    trial = (RemW+2)'({data_i.root, 2'b01});
    data_d      = data_i;
    data_d.rad  = {data_i.rad[SqW-3:0], 2'b00};
    if (rem_w >= trial) begin
      data_d.rem  = RemW'(rem_w - trial);
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = RemW'(rem_w);
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: src/ata_cordic_cell.sv
// one vectoring cordic micro-rotation cell
`default_nettype none

module ata_cordic_cell #(
  parameter int unsigned StageIdx = 0
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  ata_pkg::cordic_t data_i,
  output logic             valid_o,
  input  wire              ready_i,
  output ata_pkg::cordic_t data_o
);
  import ata_pkg::*;

  logic valid_q;
  cordic_t data_q, data_d;
  logic signed [XyW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;
  logic y_pos;

  // rotate toward the x axis; both updates use the incoming x and y
  always_comb begin
    dx    = data_i.y >>> StageIdx;
    dy    = data_i.x >>> StageIdx;
    ang   = signed'(AtanTab[StageIdx]);
    y_pos = ~data_i.y[XyW-1] & (|data_i.y);
    data_d = data_i;
    if (y_pos) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ang;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ang;
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: src/ata_scale.sv
// radians to hundredths of a degree: magnitude, multiply, round and clamp
`default_nettype none

module ata_scale (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            valid_i,
  output logic                           ready_o,
  input  ata_pkg::cordic_t               data_i,
  output logic                           valid_o,
  input  wire                            ready_i,
  output logic signed [ata_pkg::AngW-1:0] angle_o
);
  import ata_pkg::*;

  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_ready, b_ready, c_ready;

  logic            a_neg_q, b_neg_q;
  spec_e           a_spec_q, b_spec_q;
  logic [MagW-1:0] a_mag_q;
  logic [ProdW-1:0] b_prod_q;
  logic signed [AngW-1:0] c_angle_q;

  logic [ZW-1:0]    z_abs;
  logic [ProdW:0]   rounded;
  logic [ResW-1:0]  res, res_sat;
  logic signed [AngW-1:0] angle_d;

  assign c_ready = ~c_valid_q | ready_i;
  assign b_ready = ~b_valid_q | c_ready;
  assign a_ready = ~a_valid_q | b_ready;
  assign ready_o = a_ready;

  assign z_abs = data_i.z[ZW-1] ? ZW'(-data_i.z) : ZW'(data_i.z);

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  // stage a: sign and magnitude of the angle
  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_neg_q  <= data_i.z[ZW-1];
      a_spec_q <= data_i.spec;
      a_mag_q  <= MagW'(z_abs);
    end
  end

  // stage b: multiply by 18000/pi
  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_neg_q  <= a_neg_q;
      b_spec_q <= a_spec_q;
      b_prod_q <= ProdW'(a_mag_q * Deg100PerRad);
    end
  end

  // stage c: round half away from zero, clamp, restore sign; special samples take a fixed result
  always_comb begin
    rounded = {1'b0, b_prod_q} + ((ProdW+1)'(1) << (RndBit - 1));
    res     = rounded[ProdW:RndBit];
    res_sat = (res > AngMax) ? AngMax : res;
    case (b_spec_q)
      SpecZero: angle_d = '0;
      SpecPos:  angle_d = AngW'(AngMax);
      SpecNeg:  angle_d = -AngW'(AngMax);
      default:  angle_d = b_neg_q ? -AngW'(res_sat) : AngW'(res_sat);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_valid_q) begin
      c_angle_q <= angle_d;
    end
  end

  assign valid_o = c_valid_q;
  assign angle_o = c_angle_q;

endmodule

`default_nettype wire

// File: src/accel_tilt_angle.sv
// top level of the accelerometer tilt angle pipeline
// Computes roll or pitch from one raw three-axis accelerometer sample.
// Input channel: in_valid_i/in_ready_o with accel_x_i, accel_y_i, accel_z_i as
// signed 16-bit counts; a transfer happens when valid and ready are both high.
// Output channel: out_valid_o/out_ready_i with tilt_angle_o, signed, in units of
// 0.01 degree, in [-9000, 9000], rounded to nearest.
// cfg_we_i/cfg_wdata_i write axis_mode: 0 selects roll atan2(y, sqrt(x^2+z^2)),
// 1 selects pitch atan2(x, sqrt(y^2+z^2)); write only while the pipeline is empty.
// Throughput: one sample per cycle while the receiver is ready. Depth: 2 front stages + 30 square root
// cells + CORDIC_STAGES cordic cells (capped at 24) + 3 scaling stages, with
// a default of 16 cordic stages.
// Each cell has its own valid bit and its ready is ~valid | downstream ready,
// so bubbles fill up while the receiver stalls and input is held off only
// once every stage holds a result.
// Reset clears all valid bits and sets axis_mode to roll; no clearing pass.
`default_nettype none

module accel_tilt_angle #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire                               cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_x_i,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_y_i,
  input  wire  signed [ata_pkg::AccelW-1:0] accel_z_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [ata_pkg::AngW-1:0]   tilt_angle_o
);
  import ata_pkg::*;

  localparam int unsigned NumStages = (CORDIC_STAGES > TabLen) ? TabLen : CORDIC_STAGES;

  logic axis_mode_q;

  sqrt_t   sq_data  [RootW+1];
  logic    sq_valid [RootW+1];
  logic    sq_ready [RootW+1];

  cordic_t cd_data  [NumStages+1];
  logic    cd_valid [NumStages+1];
  logic    cd_ready [NumStages+1];

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      axis_mode_q <= cfg_wdata_i;
    end
  end

  // axis select and sum of squares
  ata_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (axis_mode_q),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .accel_x_i(accel_x_i),
    .accel_y_i(accel_y_i),
    .accel_z_i(accel_z_i),
    .valid_o  (sq_valid[0]),
    .ready_i  (sq_ready[0]),
    .data_o   (sq_data[0])
  );

  // square root chain, one root bit per cell
  for (genvar gi = 0; gi < RootW; gi++) begin : g_sqrt
    ata_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_valid[gi]),
      .ready_o(sq_ready[gi]),
      .data_i (sq_data[gi]),
      .valid_o(sq_valid[gi+1]),
      .ready_i(sq_ready[gi+1]),
      .data_o (sq_data[gi+1])
    );
  end

  // cordic start vector: x = root, y = numerator scaled by 2^14, z = 0
  always_comb begin
    cd_data[0].x    = XyW'(sq_data[RootW].root);
    cd_data[0].y    = XyW'(sq_data[RootW].num) <<< NumShift;
    cd_data[0].z    = '0;
    cd_data[0].spec = sq_data[RootW].spec;
  end
  assign cd_valid[0]     = sq_valid[RootW];
  assign sq_ready[RootW] = cd_ready[0];

  // cordic chain
  for (genvar gi = 0; gi < NumStages; gi++) begin : g_cordic
    ata_cordic_cell #(
      .StageIdx(gi)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cd_valid[gi]),
      .ready_o(cd_ready[gi]),
      .data_i (cd_data[gi]),
      .valid_o(cd_valid[gi+1]),
      .ready_i(cd_ready[gi+1]),
      .data_o (cd_data[gi+1])
    );
  end

  // conversion to hundredths of a degree
  ata_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(cd_valid[NumStages]),
    .ready_o(cd_ready[NumStages]),
    .data_i (cd_data[NumStages]),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .angle_o(tilt_angle_o)
  );

  // result always inside the quarter-turn range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tilt_angle_o >= -signed'(AngW'(AngMax)) &&
                     tilt_angle_o <= signed'(AngW'(AngMax))))
    else $error("tilt angle out of range");

  // input is held off only when the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // a draining output always frees room at the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output drains");

  // a held-off input means the square root entry is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> sq_valid[0])
    else $error("input stalled with empty front stage");

endmodule

`default_nettype wire

// File: dv/accel_tilt_angle_test.sv
// self-checking testbench for the accelerometer tilt angle pipeline
module accel_tilt_angle_test;
  import ata_pkg::*;

  // cordic depth of the instance and its cap
  localparam int unsigned Stages     = 16;
  localparam int unsigned MaxStages  = 24;
  localparam int unsigned AngFull    = 9000;
  // pipeline depth: 2 front + 30 root + cordic + 3 scaling, with margin
  localparam int unsigned DrainWait  = 2 + 30 + MaxStages + 3 + 10;
  // longest run with no transfer: one pipeline flush plus a long random stall
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxReports = 10;
  localparam logic ModeRoll  = 1'b0;
  localparam logic ModePitch = 1'b1;

  typedef struct packed {
    logic signed [AccelW-1:0] x;
    logic signed [AccelW-1:0] y;
    logic signed [AccelW-1:0] z;
  } sample_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_wdata_i = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [AccelW-1:0] accel_x_i = '0;
  logic signed [AccelW-1:0] accel_y_i = '0;
  logic signed [AccelW-1:0] accel_z_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [AngW-1:0]   tilt_angle_o;

  // predictor state and scoreboard
  logic                     axis_mode_q = ModeRoll;
  logic [AngW-1:0]          angle_q [$];
  logic [AngW-1:0]          angle_exp;
  int unsigned              err_count = 0;
  int unsigned              idle_cycles = 0;
  int unsigned              send_idle_pct = 0;
  int unsigned              recv_idle_pct = 0;

  // atan(2^-i) in radians scaled by 2^30, truncated
  longint atan_rad30 [MaxStages] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767,
    16383,     8191,      4095,      2047,
    1023,      511,       255,       127
  };

  accel_tilt_angle #(
    .CORDIC_STAGES(Stages)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tilt_angle_o (tilt_angle_o)
  );

  always #5 clk_i = ~clk_i;

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 29; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // expected angle in hundredths of a degree for one sample
  function automatic logic [AngW-1:0] predict_tilt(input logic mode,
                                                   input sample_t s);
    longint num, pa, pb, x, y, z, dx, dy, res;
    longint unsigned mag;
    int unsigned n_stages;
    num = mode ? longint'(s.x) : longint'(s.y);
    pa  = mode ? longint'(s.y) : longint'(s.x);
    pb  = longint'(s.z);
    x = longint'(floor_root(longint'(pa * pa + pb * pb) << 28));
    y = num * 16384;
    z = 0;
    // level numerator, then vertical denominator
    if (num == 0) return '0;
    if (x == 0) return (num > 0) ? AngW'(AngFull) : AngW'(-int'(AngFull));
    n_stages = (Stages > MaxStages) ? MaxStages : Stages;
    // vectoring rotations drive y toward zero
    for (int i = 0; i < int'(n_stages); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_rad30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_rad30[i];
      end
    end
    // scale to hundredths of a degree, round half away from zero
    mag = longint'(z < 0 ? -z : z) * 64'd375493621;
    res = longint'((mag + (64'd1 << 45)) >> 46);
    if (res > longint'(AngFull)) res = AngFull;
    if (z < 0) res = -res;
    return AngW'(res);
  endfunction

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard: check the result transfer, then predict the sample transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (angle_q.size() == 0) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("unexpected result: tilt_angle %0d", tilt_angle_o);
        end else begin
          angle_exp = angle_q.pop_front();
          if (tilt_angle_o !== angle_exp) begin
            err_count++;
            if (err_count <= MaxReports)
              $display("tilt_angle mismatch: expected %0d actual %0d",
                       $signed(angle_exp), tilt_angle_o);
          end
        end
      end
      if (in_valid_i && in_ready_o)
        angle_q.push_back(predict_tilt(axis_mode_q,
                                       {accel_x_i, accel_y_i, accel_z_i}));
      if (cfg_we_i) axis_mode_q = cfg_wdata_i;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one sample transfer, with random idle cycles before it
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= s.x;
    accel_y_i  <= s.y;
    accel_z_i  <= s.z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off input until every expected angle has come back
  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (angle_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // mode change on an empty pipeline
  task automatic write_mode(input logic mode);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic signed [AccelW-1:0] edge_value();
    case ($urandom_range(6))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return 16'sh7fff;
      3:       return -16'sd1;
      4:       return 16'sd1;
      5:       return 16'sd0;
      default: return 16'sh4000;
    endcase
  endfunction

  function automatic logic signed [AccelW-1:0] small_value();
    return AccelW'(int'($urandom_range(128)) - 64);
  endfunction

  // random sample: full range half of the time, plus edges, zeros, mixes
  function automatic sample_t random_sample();
    sample_t s;
    int unsigned pick;
    s = sample_t'((3*AccelW)'({$urandom(), $urandom()}));
    case ($urandom_range(9))
      5: s = '{small_value(), small_value(), small_value()};
      6: s = '{edge_value(), edge_value(), edge_value()};
      7: begin
        pick = $urandom_range(2);
        if (pick == 0) s.x = '0;
        else if (pick == 1) s.y = '0;
        else s.z = '0;
      end
      8: begin
        pick = $urandom_range(2);
        if (pick != 0) s.x = '0;
        if (pick != 1) s.y = '0;
        if (pick != 2) s.z = '0;
      end
      9: begin
        if ($urandom_range(1)) s.x = small_value();
        if ($urandom_range(1)) s.y = small_value();
        if ($urandom_range(1)) s.z = small_value();
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(random_sample());
  endtask

  // roll in the reset mode: zero sample, vertical axis, full scale corners
  task automatic test_roll_edges;
    send_sample('{16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd5, 16'sd0, -16'sd7});
    send_sample('{16'sd0, 16'sd1, 16'sd0});
    send_sample('{16'sd0, 16'sh8000, 16'sd0});
    send_sample('{16'sd0, 16'sh7fff, 16'sd0});
    send_sample('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_sample('{16'sh8000, 16'sh8000, 16'sh8000});
    send_sample('{16'sh8000, 16'sh7fff, 16'sh8000});
    send_sample('{16'sd1, -16'sd1, 16'sd1});
    send_sample('{16'sd0, 16'sd0, 16'sd16384});
    send_sample('{16'sd0, 16'sd8192, 16'sd8192});
  endtask

  // pitch: same special cases on the X axis
  task automatic test_pitch_edges;
    write_mode(ModePitch);
    send_sample('{16'sd0, 16'sd0, 16'sd0});
    send_sample('{16'sd0, 16'sd7, -16'sd3});
    send_sample('{16'sd1, 16'sd0, 16'sd0});
    send_sample('{16'sh8000, 16'sd0, 16'sd0});
    send_sample('{16'sh7fff, 16'sh8000, 16'sh8000});
    send_sample('{16'sh8000, 16'sh7fff, 16'sh7fff});
    send_sample('{-16'sd1, 16'sd0, 16'sd1});
    send_sample('{16'sd4096, 16'sd0, -16'sd4096});
    send_sample('{-16'sd12345, 16'sd23456, -16'sd345});
  endtask

  // light sender gaps, heavy receiver stalls, roll
  task automatic test_random_recv_stall;
    write_mode(ModeRoll);
    send_idle_pct = 13;
    recv_idle_pct = 55;
    send_random(310);
  endtask

  // heavy sender gaps, light receiver stalls, pitch
  task automatic test_random_send_stall;
    write_mode(ModePitch);
    send_idle_pct = 55;
    recv_idle_pct = 13;
    send_random(310);
  endtask

  // back to back in both modes
  task automatic test_random_no_idle;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(ModeRoll);
    send_random(155);
    write_mode(ModePitch);
    send_random(155);
  endtask

  initial begin
    send_idle_pct = 13;
    recv_idle_pct = 55;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_roll_edges();
    test_pitch_edges();
    test_random_recv_stall();
    test_random_send_stall();
    test_random_no_idle();
    drain();
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && angle_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
